[sv/strip_grid_quantizer_core_assert.svh]
// assertion macros for the strip grid quantizer core
// expects signals named clock and reset in the including module
`ifndef STRIP_GRID_QUANTIZER_CORE_ASSERT_SVH
`define STRIP_GRID_QUANTIZER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define SGQ_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("strip_grid_quantizer_core: same-cycle check failed");

// next-cycle implication, off during reset
`define SGQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("strip_grid_quantizer_core: next-cycle check failed");

`endif

[sv/sgq_pkg.sv]
// types, widths and helpers for the strip grid quantizer core
// no dependencies; imported by strip_grid_quantizer_core
package sgq_pkg;

   localparam int MaxStrips   = 4096;
   localparam int HitW        = 24;
   localparam int VolW        = 24;
   localparam int WidthW      = 24;
   localparam int OffW        = 23;
   localparam int CountW      = 13;
   localparam int TolW        = 8;
   localparam int IndexW      = 12;
   localparam int PitchW      = 25;
   localparam int PosW        = 25;
   localparam int CofsW       = 27;
   localparam int LimW        = CountW + PitchW;
   localparam int ProdW       = IndexW + PitchW;
   localparam int CsrIdxW     = 3;
   localparam int CsrDataW    = 24;
   localparam int CfgDivSteps = 25;
   localparam int CfgCntW     = $clog2(CfgDivSteps);

   typedef enum logic [CsrIdxW-1:0] {
      REG_VOLUME_SIZE,
      REG_STRIP_WIDTH,
      REG_STRIP_OFFSET,
      REG_STRIP_COUNT,
      REG_EDGE_TOLERANCE
   } csr_reg_type;

   typedef enum logic [2:0] {
      CFG_IDLE,
      CFG_CHECK,
      CFG_DIVIDE,
      CFG_SELECT,
      CFG_SCALE
   } cfg_state_type;

   typedef struct packed {
      logic ready;
      logic busy;
      logic load;
      logic step;
      logic select;
      logic scale;
   } cfg_ctrl_type;

   // one stage of the hit divider: word holds dividend bits on top, quotient bits below
   typedef struct packed {
      logic              valid;
      logic              bad;
      logic              tail_ok;
      logic [PitchW-1:0] rem;
      logic [PosW-1:0]   word;
   } div_stage_type;

   typedef struct packed {
      logic [IndexW-1:0]      strip_index;
      logic                   index_valid;
      logic signed [HitW-1:0] grid_position;
      logic                   geometry_error;
   } result_type;

   // one restoring division step by the strip pitch
   function automatic div_stage_type div_step(input div_stage_type s,
                                              input logic [PitchW-1:0] pitch);
      logic [PitchW:0] rs;
      logic            ge;
      div_stage_type   r;
      rs = {s.rem, s.word[PosW-1]};
      ge = (rs >= {1'b0, pitch});
      r = s;
      r.rem  = ge ? PitchW'(rs - {1'b0, pitch}) : rs[PitchW-1:0];
      r.word = {s.word[PosW-2:0], ge};
      return r;
   endfunction

endpackage

[sv/strip_grid_quantizer_core.sv]
// strip grid quantizer core: one detector axis, hit coordinate to strip index and grid point
// depends on sgq_pkg and strip_grid_quantizer_core_assert.svh
//
//   channel | ports                        | handshake
//   req     | req_hit_position             | req_valid / req_stall
//   rsp     | rsp_strip_index .. geo error | rsp_valid / rsp_stall
//   csr     | csr_index, csr_wdata         | csr_valid / csr_ready
//
// one hit per cycle while req_stall is low, through the 25-stage pitch divider plus
// input, check, multiply and output registers
// after reset and after each register write the geometry is recomputed (serial pitch
// divide by strip_count-1); csr_ready and req_stall stay busy meanwhile
// a two-entry output (register plus skid) lets the pipeline run while a result waits;
// req_stall rises when the skid entry is full or while the geometry is recomputed
`include "strip_grid_quantizer_core_assert.svh"

module strip_grid_quantizer_core
   import sgq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [HitW-1:0] req_hit_position,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [IndexW-1:0]      rsp_strip_index,
   output logic                   rsp_index_valid,
   output logic signed [HitW-1:0] rsp_grid_position,
   output logic                   rsp_geometry_error,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxW-1:0]     csr_index,
   input  logic [CsrDataW-1:0]    csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [VolW-1:0]   vol_ff;
   logic [WidthW-1:0] sw_ff;
   logic [OffW-1:0]   off_ff;
   logic [CountW-1:0] cnt_ff;
   logic [TolW-1:0]   tol_ff;
   logic              csr_wr;

   assign csr_wr = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_ff <= '0;
         sw_ff  <= '0;
         off_ff <= '0;
         cnt_ff <= CountW'(1);
         tol_ff <= TolW'(1);
      end else if (csr_wr) begin
         case (csr_index)
            REG_VOLUME_SIZE:    vol_ff <= csr_wdata[VolW-1:0];
            REG_STRIP_WIDTH:    sw_ff  <= csr_wdata[WidthW-1:0];
            REG_STRIP_OFFSET:   off_ff <= csr_wdata[OffW-1:0];
            REG_STRIP_COUNT:    cnt_ff <= csr_wdata[CountW-1:0];
            REG_EDGE_TOLERANCE: tol_ff <= csr_wdata[TolW-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- geometry recompute sequencer ----------------
   cfg_state_type state_ff, state_in;
   cfg_ctrl_type  ctrl;
   logic [CfgCntW-1:0] cdiv_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CFG_CHECK;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CFG_IDLE:   if (csr_wr) state_in = CFG_CHECK;
         CFG_CHECK:  state_in = CFG_DIVIDE;
         CFG_DIVIDE: if (cdiv_cnt_ff == CfgCntW'(CfgDivSteps - 1)) state_in = CFG_SELECT;
         CFG_SELECT: state_in = CFG_SCALE;
         CFG_SCALE:  state_in = CFG_IDLE;
         default:    state_in = CFG_CHECK;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         CFG_IDLE:   ctrl.ready = 1'b1;
         CFG_CHECK: begin
            ctrl.busy = 1'b1;
            ctrl.load = 1'b1;
         end
         CFG_DIVIDE: begin
            ctrl.busy = 1'b1;
            ctrl.step = 1'b1;
         end
         CFG_SELECT: begin
            ctrl.busy   = 1'b1;
            ctrl.select = 1'b1;
         end
         CFG_SCALE: begin
            ctrl.busy  = 1'b1;
            ctrl.scale = 1'b1;
         end
         default:    ctrl.busy = 1'b1;
      endcase
   end

   assign csr_ready = ctrl.ready;

   // derived geometry
   logic [CountW+WidthW-1:0] nsw_ff;
   logic                     span_neg_ff;
   logic [CountW-1:0]        cdiv_rem_ff;
   logic [PosW-1:0]          cdiv_word_ff;
   logic [PitchW-1:0]        pitch_ff;
   logic [PitchW-1:0]        w2_ff;
   logic signed [CofsW-1:0]  cofs_ff;
   logic [LimW-1:0]          lim_ff;
   logic                     geo_ff;
   logic                     ok_ff;

   logic signed [WidthW+1:0] span;
   logic [CountW-1:0]        cnt_m1;
   logic [CountW:0]          cdiv_rs;
   logic                     cdiv_ge;
   logic                     one_strip;
   logic                     single_wide;
   logic                     err_count;
   logic                     err_fit;
   logic                     err_single;
   logic [VolW-1:0]          dvol;
   logic [VolW-1:0]          eff;
   logic                     take_q;
   logic [PitchW-1:0]        pitch_sel;

   assign span = $signed({2'b00, vol_ff}) - $signed({2'b00, off_ff, 1'b0})
               - $signed({2'b00, sw_ff});
   assign cnt_m1  = cnt_ff - CountW'(1);
   assign cdiv_rs = {cdiv_rem_ff, cdiv_word_ff[PosW-1]};
   assign cdiv_ge = (cdiv_rs >= {1'b0, cnt_m1});

   assign one_strip   = (cnt_ff[CountW-1:1] == '0);
   assign single_wide = one_strip && (off_ff == '0);
   assign err_count   = (cnt_ff == '0) || (32'(cnt_ff) > 32'(MaxStrips));
   assign err_fit     = (LimW'(vol_ff) < (LimW'(nsw_ff) + LimW'({off_ff, 1'b0})));
   assign dvol        = (sw_ff >= vol_ff) ? (sw_ff - vol_ff) : (vol_ff - sw_ff);
   assign err_single  = single_wide && (dvol > (VolW'(tol_ff) * VolW'(10)));
   assign eff         = single_wide ? vol_ff : sw_ff;
   // wider pitch only when the dead gap is at least the tolerance
   assign take_q      = !span_neg_ff &&
                        ({1'b0, cdiv_word_ff} >= ({1'b0, sw_ff, 1'b0} + (PosW+1)'({tol_ff, 1'b0})));
   assign pitch_sel   = one_strip ? {eff, 1'b0} : (take_q ? cdiv_word_ff : {sw_ff, 1'b0});

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         nsw_ff       <= (CountW+WidthW)'(cnt_ff) * (CountW+WidthW)'(sw_ff);
         span_neg_ff  <= span[WidthW+1];
         cdiv_word_ff <= span[WidthW+1] ? '0 : {span[WidthW-1:0], 1'b0};
         cdiv_rem_ff  <= '0;
         cdiv_cnt_ff  <= '0;
      end
      if (ctrl.step) begin
         cdiv_rem_ff  <= cdiv_ge ? CountW'(cdiv_rs - {1'b0, cnt_m1}) : cdiv_rs[CountW-1:0];
         cdiv_word_ff <= {cdiv_word_ff[PosW-2:0], cdiv_ge};
         cdiv_cnt_ff  <= cdiv_cnt_ff + CfgCntW'(1);
      end
      if (ctrl.select) begin
         pitch_ff <= pitch_sel;
         w2_ff    <= {eff, 1'b0};
         geo_ff   <= err_count || err_fit || err_single;
         cofs_ff  <= $signed({3'b000, vol_ff}) - $signed({3'b000, eff})
                   - $signed({3'b000, off_ff, 1'b0});
      end
      if (ctrl.scale) begin
         lim_ff <= LimW'(cnt_ff) * LimW'(pitch_ff) + LimW'({tol_ff, 1'b0});
         ok_ff  <= !geo_ff && (pitch_ff != '0);
      end
   end

   // ---------------- hit pipeline ----------------
   logic          skid_valid_ff;
   logic          pipe_en;
   logic          req_take;

   assign pipe_en   = !skid_valid_ff;
   assign req_stall = ctrl.busy || !pipe_en;
   assign req_take  = req_valid && !req_stall;

   // stage 0: half-micrometre position from the volume edge
   logic signed [CofsW-1:0] ppos;
   div_stage_type           st0;

   assign ppos = $signed({{2{req_hit_position[HitW-1]}}, req_hit_position, 1'b0})
               - $signed({3'b000, off_ff, 1'b0}) + $signed({3'b000, vol_ff});

   always_comb begin
      st0         = '0;
      st0.valid   = req_take;
      st0.bad     = ppos[CofsW-1];
      st0.tail_ok = (LimW'(ppos[PosW-1:0]) < lim_ff);
      st0.word    = ppos[PosW-1:0];
   end

   div_stage_type div_ff [0:PosW];
   div_stage_type div_in [1:PosW];

   always_comb begin
      for (int k = 1; k <= PosW; k++) begin
         div_in[k] = div_step(div_ff[k-1], pitch_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= PosW; k++) begin
            div_ff[k].valid <= 1'b0;
         end
      end else if (pipe_en) begin
         div_ff[0] <= st0;
         for (int k = 1; k <= PosW; k++) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // check stage: gap, range and last-strip edge
   logic              chk_valid_ff;
   logic              chk_hit_ff;
   logic [IndexW-1:0] chk_idx_ff;
   div_stage_type     dq;
   logic              in_range;
   logic              hit_ok;

   assign dq       = div_ff[PosW];
   assign in_range = (dq.word < PosW'(cnt_ff));
   assign hit_ok   = ok_ff && !dq.bad && (dq.rem <= w2_ff) && (in_range || dq.tail_ok);

   // multiply stage
   logic              mul_valid_ff;
   logic              mul_hit_ff;
   logic [IndexW-1:0] mul_idx_ff;
   logic [ProdW-1:0]  mul_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         chk_valid_ff <= dq.valid;
         mul_valid_ff <= chk_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         chk_hit_ff  <= hit_ok;
         chk_idx_ff  <= !hit_ok ? '0 : (in_range ? dq.word[IndexW-1:0] : cnt_m1[IndexW-1:0]);
         mul_hit_ff  <= chk_hit_ff;
         mul_idx_ff  <= chk_idx_ff;
         mul_prod_ff <= ProdW'(chk_idx_ff) * ProdW'(pitch_ff);
      end
   end

   // grid point: round half up from half micrometres, then saturate
   logic signed [ProdW+1:0] gpt;
   logic signed [ProdW+1:0] gpt_half;
   logic signed [HitW-1:0]  gpt_sat;
   result_type              item;
   logic                    push;

   assign gpt      = $signed({2'b00, mul_prod_ff}) - (ProdW+2)'(cofs_ff) + (ProdW+2)'(1);
   assign gpt_half = gpt >>> 1;

   always_comb begin
      if (gpt_half > $signed((ProdW+2)'(8388607))) begin
         gpt_sat = {1'b0, {(HitW-1){1'b1}}};
      end else if (gpt_half < -$signed((ProdW+2)'(8388608))) begin
         gpt_sat = {1'b1, {(HitW-1){1'b0}}};
      end else begin
         gpt_sat = gpt_half[HitW-1:0];
      end
      item.strip_index    = mul_idx_ff;
      item.index_valid    = mul_hit_ff;
      item.grid_position  = mul_hit_ff ? gpt_sat : '0;
      item.geometry_error = geo_ff;
   end

   assign push = mul_valid_ff && pipe_en;

   // ---------------- output register and skid ----------------
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type skid_ff;
   logic       out_load;

   assign out_load = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff  <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= skid_valid_ff ? skid_ff : item;
      end else if (push) begin
         skid_ff <= item;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_strip_index    = rsp_ff.strip_index;
   assign rsp_index_valid    = rsp_ff.index_valid;
   assign rsp_grid_position  = rsp_ff.grid_position;
   assign rsp_geometry_error = rsp_ff.geometry_error;

   // ---------------- assertions ----------------
   `SGQ_ASSERT_IMPLIES(a_skid_behind_out, skid_valid_ff, rsp_valid_ff)
   `SGQ_ASSERT_NEXT(a_write_recomputes, csr_valid && csr_ready, state_ff == CFG_CHECK)
   `SGQ_ASSERT_IMPLIES(a_miss_is_zero, rsp_valid_ff && !rsp_index_valid, (rsp_strip_index == '0) && (rsp_grid_position == '0))
   `SGQ_ASSERT_IMPLIES(a_hit_needs_geometry, rsp_valid_ff && rsp_index_valid, !rsp_geometry_error)

endmodule
